FILE: rtl/stereo_bitcrusher_assert.svh
// Assertion macros used by the checker file.
`ifndef STEREO_BITCRUSHER_ASSERT_SVH
`define STEREO_BITCRUSHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/sbc_pkg.sv
package sbc_pkg;

    localparam int STEP_W = 4;
    localparam int LEVELS_W = 25;
    localparam int RATE_W = 15;
    localparam int CFG_INDEX_W = 1;

    localparam logic [LEVELS_W-1:0] LEVELS_MIN = 25'd512;
    localparam logic [LEVELS_W-1:0] LEVELS_MAX = 25'd16777216;
    localparam logic [RATE_W-1:0]   RATE_MIN   = 15'd256;
    localparam logic [RATE_W-1:0]   RATE_MAX   = 15'd25600;
    localparam logic [RATE_W:0]     PHASE_STEP = 16'd256;

    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_LEVELS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_DIVIDER = 1'd1;

    typedef enum logic [2:0] {
        OP_ACCEPT = 3'd0,
        OP_MUL    = 3'd1,
        OP_ROUND  = 3'd2,
        OP_DIV    = 3'd3,
        OP_STORE  = 3'd4,
        OP_OUT    = 3'd5
    } sbc_op_t;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_ALWAYS   = 2'd1,
        COND_NO_HIT   = 2'd2,
        COND_DIV_MORE = 2'd3
    } sbc_cond_t;

    typedef enum logic {
        CH_LEFT  = 1'b0,
        CH_RIGHT = 1'b1
    } sbc_chan_t;

    typedef struct packed {
        sbc_op_t           op;
        sbc_chan_t         ch;
        sbc_cond_t         cond;
        logic [STEP_W-1:0] target;
    } sbc_uword_t;

    // Datapath command for the current cycle.
    typedef struct packed {
        logic      en;
        sbc_op_t   op;
        sbc_chan_t ch;
    } sbc_ctrl_t;

    localparam logic [STEP_W-1:0] STEP_ACCEPT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIV_L  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIV_R  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_OUT    = 4'd9;

    // Microcode ROM: one control word per step.
    function automatic sbc_uword_t sbc_ucode(input logic [STEP_W-1:0] step);
        sbc_uword_t w;
        w = '{op: OP_ACCEPT, ch: CH_LEFT, cond: COND_ALWAYS, target: STEP_ACCEPT};
        unique case (step)
            4'd0: w = '{op: OP_ACCEPT, ch: CH_LEFT,  cond: COND_NO_HIT,   target: STEP_OUT};
            4'd1: w = '{op: OP_MUL,    ch: CH_LEFT,  cond: COND_NONE,     target: STEP_ACCEPT};
            4'd2: w = '{op: OP_ROUND,  ch: CH_LEFT,  cond: COND_NONE,     target: STEP_ACCEPT};
            4'd3: w = '{op: OP_DIV,    ch: CH_LEFT,  cond: COND_DIV_MORE, target: STEP_DIV_L};
            4'd4: w = '{op: OP_STORE,  ch: CH_LEFT,  cond: COND_NONE,     target: STEP_ACCEPT};
            4'd5: w = '{op: OP_MUL,    ch: CH_RIGHT, cond: COND_NONE,     target: STEP_ACCEPT};
            4'd6: w = '{op: OP_ROUND,  ch: CH_RIGHT, cond: COND_NONE,     target: STEP_ACCEPT};
            4'd7: w = '{op: OP_DIV,    ch: CH_RIGHT, cond: COND_DIV_MORE, target: STEP_DIV_R};
            4'd8: w = '{op: OP_STORE,  ch: CH_RIGHT, cond: COND_NONE,     target: STEP_ACCEPT};
            4'd9: w = '{op: OP_OUT,    ch: CH_LEFT,  cond: COND_ALWAYS,   target: STEP_ACCEPT};
            default: w = '{op: OP_ACCEPT, ch: CH_LEFT, cond: COND_ALWAYS, target: STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/sbc_datapath.sv
module sbc_datapath #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sbc_pkg::sbc_ctrl_t             ctrl,
    input  logic [sbc_pkg::LEVELS_W-1:0]   levels,
    input  logic signed [SAMPLE_WIDTH-1:0] samp_left,
    input  logic signed [SAMPLE_WIDTH-1:0] samp_right,
    output logic signed [SAMPLE_WIDTH-1:0] held_left,
    output logic signed [SAMPLE_WIDTH-1:0] held_right,
    output logic                           div_more
);
    import sbc_pkg::*;

    localparam int W    = SAMPLE_WIDTH;
    localparam int QW   = W + 1;            // quotient bits
    localparam int PW   = W + LEVELS_W;     // product / numerator width
    localparam int NMW  = 17;               // |n| is at most 2^16
    localparam int RW   = LEVELS_W + 1;     // remainder, below 2*levels
    localparam int CW   = $clog2(QW);
    localparam logic [PW-1:0] HALF = PW'(1) << (W + 6);
    localparam logic [QW-1:0] SMAX_Q = QW'((1 << (W - 1)) - 1);
    localparam logic [QW-1:0] SMIN_Q = QW'(1 << (W - 1));

    logic [PW-1:0]  prod_reg, prod_next;
    logic           sign_reg, sign_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic signed [W-1:0] held_left_reg, held_left_next;
    logic signed [W-1:0] held_right_reg, held_right_next;

    logic signed [W-1:0] samp;
    logic [W-1:0]   mag;
    logic [PW-1:0]  rnd_sum;
    logic [NMW-1:0] nmag;
    logic [PW-1:0]  numer;
    logic [RW:0]    trial;
    logic [RW:0]    dvs;
    logic           ge;
    logic [W-1:0]   sat;

    always_comb begin
        samp = (ctrl.ch == CH_RIGHT) ? samp_right : samp_left;
        mag  = samp[W-1] ? W'(-samp) : samp;

        // n = round(|s| * levels / 2^(W+7)), ties away from zero
        rnd_sum = prod_reg + HALF;
        nmag    = NMW'(rnd_sum >> (W + 7));
        // numerator of round(n * 2^(W+7) / levels): n*2^(W+8) + levels over 2*levels
        numer   = ({nmag, {(PW - NMW){1'b0}}} >> (PW - NMW - W - 8)) + PW'(levels);

        // one restoring division step
        dvs   = {1'b0, levels, 1'b0};
        trial = {rem_reg, quo_reg[QW-1]};
        ge    = (trial >= dvs);

        // saturate and apply the sign
        if (!sign_reg) begin
            sat = (quo_reg > SMAX_Q) ? SMAX_Q[W-1:0] : quo_reg[W-1:0];
        end else begin
            sat = (quo_reg > SMIN_Q) ? SMIN_Q[W-1:0] : W'(-quo_reg[W-1:0]);
        end

        prod_next       = prod_reg;
        sign_next       = sign_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;

        if (ctrl.en) begin
            unique case (ctrl.op)
                OP_MUL: begin
                    prod_next = PW'(mag) * PW'(levels);
                    sign_next = samp[W-1];
                end
                OP_ROUND: begin
                    rem_next = RW'(numer >> QW);
                    quo_next = numer[QW-1:0];
                    cnt_next = CW'(QW - 1);
                end
                OP_DIV: begin
                    rem_next = ge ? RW'(trial - dvs) : trial[RW-1:0];
                    quo_next = {quo_reg[QW-2:0], ge};
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
                OP_STORE: begin
                    if (ctrl.ch == CH_RIGHT) begin
                        held_right_next = sat;
                    end else begin
                        held_left_next = sat;
                    end
                end
                OP_ACCEPT, OP_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        sign_reg <= sign_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (!aresetn) begin
            cnt_reg        <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end else begin
            cnt_reg        <= cnt_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    assign held_left  = held_left_reg;
    assign held_right = held_right_reg;
    assign div_more   = (cnt_reg != '0);

endmodule

FILE: rtl/stereo_bitcrusher.sv
// Stereo sample-and-hold bit crusher. One transaction on the s_ side carries a stereo
// frame of signed Q1.15 samples (tuser set means mono: right copies left); one
// transaction on the m_ side returns the held crushed frame. A Q7.8 phase adds 1.0
// per frame; when it reaches rate_divider (clamped to 1.0..100.0) the divider is
// subtracted once and both channels are requantized as round(round(x*L)/L) with L
// = quant_levels (Q17.8, clamped to 2.0..65536.0), ties away from zero, saturated.
// Between updates the last held values repeat; they start at zero after reset.
// Throughput: the single shared restoring divider yields one quotient bit per cycle and
// serves both channels in turn, so a frame that triggers an update takes longer than one
// that only repeats the held values. A frame is taken while the previous result still
// waits on m_tready. Write configuration only while no frame is in flight.
module stereo_bitcrusher #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input frames
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata, from bit 0: left_sample, right_sample, zero pad to whole bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    // tuser: mono
    input  logic                                  s_tuser,
    // result frames
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata, from bit 0: left_out, right_out, zero pad to whole bytes
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [sbc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [sbc_pkg::LEVELS_W-1:0]          cfg_wdata
);
    import sbc_pkg::*;

    localparam int W      = SAMPLE_WIDTH;
    localparam int DATA_W = ((2 * W + 7) / 8) * 8;

    // configuration
    logic [LEVELS_W-1:0] levels_reg, levels_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [LEVELS_W-1:0] levels_eff;
    logic [RATE_W-1:0]   rate_eff;

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    sbc_uword_t        uword;
    logic              stall;
    logic              take_jump;
    sbc_ctrl_t         ctrl;

    // phase accumulator
    logic [RATE_W-1:0] phase_reg, phase_next;
    logic [RATE_W:0]   ph_sum;
    logic [RATE_W:0]   ph_wrapped;
    logic              hit;

    // frame and result registers
    logic signed [W-1:0] left_reg, left_next;
    logic signed [W-1:0] right_reg, right_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic signed [W-1:0] held_left;
    logic signed [W-1:0] held_right;
    logic                div_more;
    logic                s_accept;

    // Clamp the registers to their legal ranges.
    always_comb begin
        levels_eff = levels_reg;
        if (levels_reg < LEVELS_MIN) begin
            levels_eff = LEVELS_MIN;
        end else if (levels_reg > LEVELS_MAX) begin
            levels_eff = LEVELS_MAX;
        end
        rate_eff = rate_reg;
        if (rate_reg < RATE_MIN) begin
            rate_eff = RATE_MIN;
        end else if (rate_reg > RATE_MAX) begin
            rate_eff = RATE_MAX;
        end
    end

    always_comb begin
        levels_next = levels_reg;
        rate_next   = rate_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_QUANT_LEVELS: levels_next = cfg_wdata;
                REG_RATE_DIVIDER: rate_next   = cfg_wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: fetch the control word, hold on a stalled handshake, else jump or advance.
    always_comb begin
        uword    = sbc_ucode(step_reg);
        s_tready = (uword.op == OP_ACCEPT);
        s_accept = s_tready && s_tvalid;

        // Advance the phase by one frame and subtract the divider once on a hit.
        ph_sum     = {1'b0, phase_reg} + PHASE_STEP;
        hit        = (ph_sum >= {1'b0, rate_eff});
        ph_wrapped = hit ? (ph_sum - {1'b0, rate_eff}) : ph_sum;

        priority case (1'b1)
            (uword.op == OP_ACCEPT): stall = !s_tvalid;
            (uword.op == OP_OUT):    stall = m_tvalid_reg && !m_tready;
            default:                 stall = 1'b0;
        endcase

        unique case (uword.cond)
            COND_NONE:     take_jump = 1'b0;
            COND_ALWAYS:   take_jump = 1'b1;
            COND_NO_HIT:   take_jump = !hit;
            COND_DIV_MORE: take_jump = div_more;
            default:       take_jump = 1'b0;
        endcase

        if (stall) begin
            step_next = step_reg;
        end else if (take_jump) begin
            step_next = uword.target;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end

        ctrl.en = !stall;
        ctrl.op = uword.op;
        ctrl.ch = uword.ch;

        phase_next = phase_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (s_accept) begin
            phase_next = ph_wrapped[RATE_W-1:0];
            left_next  = s_tdata[W-1:0];
            right_next = s_tuser ? s_tdata[W-1:0] : s_tdata[2*W-1:W];
        end

        // Load the output register at the end of the program; drop valid once taken.
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (uword.op == OP_OUT && !stall) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = DATA_W'({held_right, held_left});
        end
    end

    sbc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .levels     (levels_eff),
        .samp_left  (left_reg),
        .samp_right (right_reg),
        .held_left  (held_left),
        .held_right (held_right),
        .div_more   (div_more)
    );

    always_ff @(posedge aclk) begin
        left_reg    <= left_next;
        right_reg   <= right_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            levels_reg   <= LEVELS_MAX;
            rate_reg     <= RATE_MIN;
            step_reg     <= STEP_ACCEPT;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            levels_reg   <= levels_next;
            rate_reg     <= rate_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/sbc_checker.sv
`include "stereo_bitcrusher_assert.svh"

module sbc_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);
    logic s_accept;
    logic m_stall;

    assign s_accept = s_tvalid && s_tready;
    assign m_stall  = m_tvalid && !m_tready;

    // One frame at a time: the input side closes right after a transaction.
    `SBC_ASSERT_NEXT(a_one_frame_in_flight, aclk, aresetn, s_accept, !s_tready)

    // A fresh result is posted as the sequencer returns to taking input.
    `SBC_ASSERT_SAME(a_result_reopens_input, aclk, aresetn, $rose(m_tvalid), s_tready)

    // A stalled result holds.
    `SBC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata))

endmodule

bind stereo_bitcrusher sbc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/stereo_bitcrusher_tb.sv
`timescale 1ns / 100ps

module stereo_bitcrusher_tb;
    import sbc_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
    // Requantization scale: sample fraction bits plus level fraction bits.
    localparam int SCALE_SHIFT = SAMPLE_W - 1 + 8;
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int PHASE_MASK = (1 << RATE_W) - 1;
    localparam int RANDOM_PHASES = 12;
    localparam int FRAMES_PER_PHASE = 138;
    localparam int TAIL_CYCLES = 60;

    // One stereo frame, laid out as on tdata: left in the low half.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } stereo_frame_t;

    // Shadow of the crusher: register copies, phase, held samples and the
    // queue of frames the block still owes on its result channel.
    class crush_scoreboard;
        logic [LEVELS_W-1:0]        levels_q;
        logic [RATE_W-1:0]          divider_q;
        int                         phase_acc;
        logic signed [SAMPLE_W-1:0] held_left;
        logic signed [SAMPLE_W-1:0] held_right;
        stereo_frame_t              owed_frames[$];
        int                         errors;

        function new();
            levels_q   = LEVELS_MAX;
            divider_q  = RATE_MIN;
            phase_acc  = 0;
            held_left  = '0;
            held_right = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [LEVELS_W-1:0] data);
            if (idx == REG_QUANT_LEVELS) begin
                levels_q = data;
            end else if (idx == REG_RATE_DIVIDER) begin
                divider_q = data[RATE_W-1:0];
            end
        endfunction

        // Divide with ties rounded away from zero; den is always positive.
        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function logic signed [SAMPLE_W-1:0] crush(logic signed [SAMPLE_W-1:0] s,
                                                   longint lv);
            longint n;
            longint y;
            n = round_div(longint'(s) * lv, longint'(1) << SCALE_SHIFT);
            y = round_div(n * (longint'(1) << SCALE_SHIFT), lv);
            if (y > SAMPLE_MAX) y = SAMPLE_MAX;
            if (y < SAMPLE_MIN) y = SAMPLE_MIN;
            return y[SAMPLE_W-1:0];
        endfunction

        // Advance the phase by one frame and queue the frame the block must return.
        function void note_frame(logic signed [SAMPLE_W-1:0] l,
                                 logic signed [SAMPLE_W-1:0] r, logic mono);
            longint        lv;
            longint        rd;
            longint        ph;
            stereo_frame_t owed;
            lv = longint'(levels_q);
            if (lv < longint'(LEVELS_MIN)) lv = longint'(LEVELS_MIN);
            if (lv > longint'(LEVELS_MAX)) lv = longint'(LEVELS_MAX);
            rd = longint'(divider_q);
            if (rd < longint'(RATE_MIN)) rd = longint'(RATE_MIN);
            if (rd > longint'(RATE_MAX)) rd = longint'(RATE_MAX);
            ph = longint'(phase_acc) + longint'(PHASE_STEP);
            // Subtract the divider at most once, even if the phase stays ahead.
            if (ph >= rd) begin
                ph = ph - rd;
                held_left  = crush(l, lv);
                held_right = crush(mono ? l : r, lv);
            end
            phase_acc = int'(ph) & PHASE_MASK;
            owed.left  = held_left;
            owed.right = held_right;
            owed_frames.push_back(owed);
        endfunction

        function int pending();
            return owed_frames.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_frame(stereo_frame_t got);
            stereo_frame_t want;
            if (owed_frames.size() == 0) begin
                report($sformatf("unexpected result frame %h", got));
            end else begin
                want = owed_frames.pop_front();
                if (got.left !== want.left)
                    report($sformatf("left_out %0d, want %0d", got.left, want.left));
                if (got.right !== want.right)
                    report($sformatf("right_out %0d, want %0d", got.right, want.right));
            end
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DATA_W-1:0]      m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_QUANT_LEVELS;
    logic [LEVELS_W-1:0]    cfg_wdata = '0;

    // Idle odds in percent, changed between traffic phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    crush_scoreboard sb = new();

    stereo_bitcrusher #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Generous hard stop: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Stall the result channel at random; redraw every cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on every accepted input transaction.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_frame(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W], s_tuser);
        end
    end

    // Check every accepted result transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_frame(m_tdata[2*SAMPLE_W-1:0]);
        end
    end

    // Write one register; call only while no frame is in flight.
    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [LEVELS_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offer one frame, holding valid across back-to-back frames, and return
    // at the edge where it is accepted.
    task send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                    logic mono);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {{(DATA_W - 2 * SAMPLE_W){1'b0}}, r, l};
        s_tuser  <= mono;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every owed frame has come back.
    task drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Mix of full-range values, extremes and values with cleared low bits;
    // the latter can land exactly on rounding ties for power-of-two levels.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned      roll;
        logic [SAMPLE_W-1:0] v;
        roll = $urandom_range(99);
        v = SAMPLE_W'($urandom);
        if (roll < 15) begin
            case ($urandom_range(4))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                2: v = 16'h0000;
                3: v = 16'hFFFF;
                default: v = 16'h0001;
            endcase
        end else if (roll < 50) begin
            v = v & ~((16'd1 << $urandom_range(14)) - 16'd1);
        end
        return v;
    endfunction

    task pick_config();
        logic [LEVELS_W-1:0] lv;
        logic [LEVELS_W-1:0] rd;
        case ($urandom_range(5))
            0: lv = LEVELS_MIN;
            1: lv = LEVELS_MAX;
            2: lv = LEVELS_W'($urandom_range(LEVELS_MAX, LEVELS_MIN));
            3: lv = 25'd1 << $urandom_range(24, 9);
            4: lv = LEVELS_W'($urandom_range(511));    // below range, clamps up
            default: lv = LEVELS_W'($urandom);         // often above range
        endcase
        case ($urandom_range(5))
            0: rd = LEVELS_W'(RATE_MIN);
            1: rd = LEVELS_W'(RATE_MAX);
            2: rd = LEVELS_W'($urandom_range(RATE_MAX, RATE_MIN));
            3, 4: rd = LEVELS_W'($urandom_range(1024, 0));    // frequent updates
            default: rd = LEVELS_W'($urandom);                // upper bits dropped
        endcase
        write_reg(REG_QUANT_LEVELS, lv);
        write_reg(REG_RATE_DIVIDER, rd);
    endtask

    initial begin
        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: finest levels, update every frame; extremes and mono.
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh0000, -16'sd1, 1'b0);
        send_frame(16'sd1, -16'sd1, 1'b1);
        send_frame(16'sh8000, 16'sd5, 1'b1);
        drain();

        // Two levels: exact ties go away from zero, +1.0 saturates.
        write_reg(REG_QUANT_LEVELS, LEVELS_MIN);
        send_frame(16'sd8192, -16'sd8192, 1'b0);
        send_frame(16'sd24576, -16'sd24576, 1'b0);
        send_frame(16'sd8191, -16'sd8193, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sd16384, 16'sd0, 1'b1);
        drain();

        // Both registers below their range.
        write_reg(REG_QUANT_LEVELS, '0);
        write_reg(REG_RATE_DIVIDER, '0);
        send_frame(16'sd8192, -16'sd1, 1'b0);
        send_frame(-16'sd24576, 16'sd100, 1'b0);
        drain();

        // Both registers at and above their top; most frames repeat the hold.
        write_reg(REG_QUANT_LEVELS, '1);
        write_reg(REG_RATE_DIVIDER, LEVELS_W'(RATE_MAX));
        repeat (8) send_frame(pick_sample(), pick_sample(), 1'b0);
        drain();

        // Lower the divider with the phase far ahead: one subtraction per frame.
        write_reg(REG_RATE_DIVIDER, LEVELS_W'(RATE_MIN));
        send_frame(16'sd1000, -16'sd1000, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        drain();
        write_reg(REG_RATE_DIVIDER, 25'h1FF_FFFF);
        send_frame(16'sd12345, -16'sd321, 1'b1);
        drain();

        // Random traffic, cycling the idle patterns across phases.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            pick_config();
            for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
                send_frame(pick_sample(), pick_sample(), $urandom_range(3) == 0);
            end
            drain();
        end

        // Let any stray late result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sbc_pkg.sv
rtl/sbc_datapath.sv
rtl/stereo_bitcrusher.sv
rtl/sbc_checker.sv
tb/stereo_bitcrusher_tb.sv
